>>> rtl/ohr_pkg.sv
// Package for the ordinal history ring: command and status codes,
// request/response word layouts, stored entry layout and controller states.
// Used by ohr_slot_ram and ordinal_history_ring.
`default_nettype none

package ohr_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int OW = 48;
	localparam logic [OW-1:0] ORD_LAST = 48'hFFFF_FFFF_FFFF;
	localparam logic [6:0] MAX_RES = 7'd64;

	typedef enum logic [2:0] {
		CMD_RECORD = 3'd0,
		CMD_GET    = 3'd1,
		CMD_FIND   = 3'd2,
		CMD_LATEST = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MISS      = 3'd1,
		ST_FUTURE    = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_EXHAUSTED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic [2:0]    cmd;
		logic [OW-1:0] ordinal;
		logic [31:0]   coll_id;
		logic [15:0]   attempt_no;
		logic          any_attempt;
		logic [63:0]   payload;
		logic [6:0]    limit;
	} req_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [OW-1:0] out_ordinal;
		logic [31:0]   out_coll_id;
		logic [15:0]   out_attempt;
		logic [63:0]   out_payload;
		logic [8:0]    stored_count;
		logic [OW-1:0] evicted_total;
		logic [OW-1:0] oldest_ordinal;
		logic [OW-1:0] upcoming_ordinal;
		logic          last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] coll_id;
		logic [15:0] attempt;
		logic [63:0] payload;
	} entry_t;

endpackage

`default_nettype wire

>>> rtl/ohr_slot_ram.sv
// Slot storage of the ordinal history ring: one write port and one read
// port with registered read data. Depends on ohr_pkg for the entry layout.
`default_nettype none

module ohr_slot_ram
	import ohr_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output      entry_t        rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_q;

	// No reset: only slots that have been written are ever read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

>>> rtl/ordinal_history_ring.sv
// Ordinal history ring: a bounded trace buffer that numbers each record with
// a 48-bit ordinal, keeps the newest capacity records in a DEPTH-slot RAM and
// answers get, find and latest queries with status words. Find walks the held
// records newest first through the single RAM read port, one slot per cycle.
// Latest delivers one word per cycle while the result register can take it,
// after its first slot read. The controller waits in the emit state while the
// result register is full and rsp_ready is low. Lowering capacity evicts the
// surplus in the same cycle as the write. There is no clearing pass after
// reset. Depends on ohr_pkg and ohr_slot_ram.
`default_nettype none

module ordinal_history_ring
	import ohr_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic [8:0] cfg_data,
	input  wire logic       req_valid,
	output      logic       req_ready,
	input  wire req_t       req,
	output      logic       rsp_valid,
	input  wire logic       rsp_ready,
	output      rsp_t       rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [8:0] CAP_MAX = (DEPTH > 511) ? 9'd511 : 9'(DEPTH);
	localparam logic [AW-1:0] SLOT_LAST = AW'(DEPTH - 1);

	state_t        state_q;
	status_t       status_q;
	logic [OW-1:0] cur_q;
	logic [AW-1:0] cur_slot_q;
	logic [8:0]    rem_q;
	logic          ent_q;
	logic          multi_q;
	logic [31:0]   id_q;
	logic [15:0]   att_q;
	logic          any_q;

	logic [OW-1:0] oldest_q;
	logic [OW-1:0] next_q;
	logic [AW-1:0] next_slot_q;
	logic [8:0]    held_q;
	logic [OW-1:0] evict_q;
	logic [8:0]    cap_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic          accept;
	logic          rsp_free;
	logic          emit_fire;
	cmd_t          cmd;
	logic [AW-1:0] newest_slot;
	logic [AW-1:0] cur_slot_prev;
	logic [AW-1:0] next_slot_inc;
	logic [AW-1:0] get_dist;
	logic [AW:0]   get_raw;
	logic [AW-1:0] get_slot;
	logic          get_future;
	logic          get_evicted;
	logic [6:0]    lim_c;
	logic [8:0]    lat_n;
	logic [8:0]    cap_new;
	logic          match;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        wr_data;
	entry_t        rd_data;
	rsp_t          rsp_n;
	status_t       acc_status;
	logic [OW-1:0] acc_cur;
	logic          acc_ent;
	logic          acc_multi;
	logic [8:0]    acc_rem;
	state_t        acc_state;

	assign cfg_ready = (state_q == S_IDLE);
	assign req_ready = (state_q == S_IDLE) && !cfg_valid;
	assign accept = req_valid && req_ready;
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign emit_fire = (state_q == S_EMIT) && rsp_free;
	assign cmd = cmd_t'(req.cmd);

	assign newest_slot = (next_slot_q == '0) ? SLOT_LAST : next_slot_q - AW'(1);
	assign cur_slot_prev = (cur_slot_q == '0) ? SLOT_LAST : cur_slot_q - AW'(1);
	assign next_slot_inc = (next_slot_q == SLOT_LAST) ? '0 : next_slot_q + AW'(1);

	// A retained ordinal lies less than DEPTH below the newest one, so its
	// distance follows from the low bits alone and its slot is the newest
	// slot stepped back by that distance, wrapping once at most.
	assign get_dist = next_q[AW-1:0] - req.ordinal[AW-1:0] - AW'(1);
	assign get_raw = {1'b0, newest_slot} - {1'b0, get_dist};
	assign get_slot = get_raw[AW] ? AW'(get_raw + (AW+1)'(DEPTH)) : get_raw[AW-1:0];
	assign get_future = (req.ordinal >= next_q);
	assign get_evicted = (req.ordinal < oldest_q);

	assign lim_c = (req.limit == '0) ? 7'd1 : ((req.limit > MAX_RES) ? MAX_RES : req.limit);
	assign lat_n = ({2'b00, lim_c} < held_q) ? {2'b00, lim_c} : held_q;

	assign cap_new = (cfg_data == '0) ? 9'd1 : ((cfg_data > CAP_MAX) ? CAP_MAX : cfg_data);

	assign match = (rd_data.coll_id == id_q) && (any_q || (rd_data.attempt == att_q));

	assign wr_en = accept && (cmd == CMD_RECORD) && (next_q != ORD_LAST);
	assign wr_data = '{coll_id: req.coll_id, attempt: req.attempt_no, payload: req.payload};

	// Result setup for an accepted word.
	always_comb begin
		acc_status = ST_OK;
		acc_cur = '0;
		acc_ent = 1'b0;
		acc_multi = 1'b0;
		acc_rem = 9'd1;
		acc_state = S_EMIT;
		unique case (cmd)
			CMD_RECORD: begin
				if (next_q == ORD_LAST) begin
					acc_status = ST_EXHAUSTED;
				end else begin
					acc_cur = next_q;
				end
			end
			CMD_GET: begin
				if (held_q == '0) begin
					acc_status = ST_EMPTY;
				end else if (get_future) begin
					acc_status = ST_FUTURE;
				end else if (get_evicted) begin
					acc_status = ST_MISS;
				end else begin
					acc_cur = req.ordinal;
					acc_ent = 1'b1;
				end
			end
			CMD_FIND: begin
				if (held_q == '0) begin
					acc_status = ST_EMPTY;
				end else begin
					acc_cur = next_q - OW'(1);
					acc_rem = held_q;
					acc_state = S_SCAN;
				end
			end
			CMD_LATEST: begin
				if (held_q == '0) begin
					acc_status = ST_EMPTY;
				end else begin
					acc_cur = next_q - OW'(1);
					acc_rem = lat_n;
					acc_ent = 1'b1;
					acc_multi = 1'b1;
				end
			end
			default: begin
				acc_status = ST_OK;
			end
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = newest_slot;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (cmd == CMD_GET)) begin
					rd_en = (held_q != '0) && !get_future && !get_evicted;
					rd_addr = get_slot;
				end else if (accept && ((cmd == CMD_FIND) || (cmd == CMD_LATEST))) begin
					rd_en = (held_q != '0);
				end
			end
			S_SCAN: begin
				rd_en = !match && (rem_q != 9'd1);
				rd_addr = cur_slot_prev;
			end
			S_EMIT: begin
				rd_en = rsp_free && multi_q && (rem_q != 9'd1);
				rd_addr = cur_slot_prev;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	ohr_slot_ram #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(next_slot_q),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		rsp_n.status = status_q;
		rsp_n.out_ordinal = cur_q;
		rsp_n.out_coll_id = ent_q ? rd_data.coll_id : '0;
		rsp_n.out_attempt = ent_q ? rd_data.attempt : '0;
		rsp_n.out_payload = ent_q ? rd_data.payload : '0;
		rsp_n.stored_count = held_q;
		rsp_n.evicted_total = evict_q;
		rsp_n.oldest_ordinal = oldest_q;
		rsp_n.upcoming_ordinal = next_q;
		rsp_n.last = !multi_q || (rem_q == 9'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= ST_OK;
			cur_q <= '0;
			cur_slot_q <= '0;
			ent_q <= 1'b0;
			multi_q <= 1'b0;
			rem_q <= '0;
			id_q <= '0;
			att_q <= '0;
			any_q <= 1'b0;
			oldest_q <= OW'(1);
			next_q <= OW'(1);
			next_slot_q <= AW'(1);
			held_q <= '0;
			evict_q <= '0;
			cap_q <= CAP_MAX;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				rsp_q <= rsp_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						cap_q <= cap_new;
						if (held_q > cap_new) begin
							held_q <= cap_new;
							oldest_q <= oldest_q + OW'(held_q - cap_new);
							evict_q <= evict_q + OW'(held_q - cap_new);
						end
					end else if (accept) begin
						status_q <= acc_status;
						cur_q <= acc_cur;
						cur_slot_q <= newest_slot;
						ent_q <= acc_ent;
						multi_q <= acc_multi;
						rem_q <= acc_rem;
						id_q <= req.coll_id;
						att_q <= req.attempt_no;
						any_q <= req.any_attempt;
						state_q <= acc_state;
						if ((cmd == CMD_RECORD) && (next_q != ORD_LAST)) begin
							next_q <= next_q + OW'(1);
							next_slot_q <= next_slot_inc;
							// Holding capacity already: the new word pushes out the oldest.
							if (held_q == cap_q) begin
								oldest_q <= oldest_q + OW'(1);
								evict_q <= evict_q + OW'(1);
							end else begin
								held_q <= held_q + 9'd1;
							end
						end else if (cmd == CMD_CLEAR) begin
							held_q <= '0;
							oldest_q <= OW'(1);
							next_q <= OW'(1);
							next_slot_q <= AW'(1);
							evict_q <= '0;
						end
					end
				end
				S_SCAN: begin
					if (match) begin
						ent_q <= 1'b1;
						state_q <= S_EMIT;
					end else if (rem_q == 9'd1) begin
						status_q <= ST_MISS;
						cur_q <= '0;
						state_q <= S_EMIT;
					end else begin
						cur_q <= cur_q - OW'(1);
						cur_slot_q <= cur_slot_prev;
						rem_q <= rem_q - 9'd1;
					end
				end
				S_EMIT: begin
					if (rsp_free) begin
						// Latest keeps emitting while the next slot read is in flight.
						if (multi_q && (rem_q != 9'd1)) begin
							cur_q <= cur_q - OW'(1);
							cur_slot_q <= cur_slot_prev;
							rem_q <= rem_q - 9'd1;
						end else begin
							multi_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Testbench for ordinal_history_ring: drives request words and capacity writes,
// predicts every response word in a scoreboard class and checks each field.
// Depends on ohr_pkg and the ordinal_history_ring RTL.
`timescale 1ns / 1ps

module tb_top
	import ohr_pkg::*;
();

	localparam int HISTORY_SLOTS = DEPTH_DEF;
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
	localparam logic [8:0] CAP_ALL_ONES = 9'h1FF;

	class history_ledger;
		entry_t slots [HISTORY_SLOTS];
		logic [OW-1:0] oldest;
		logic [OW-1:0] upcoming;
		logic [OW-1:0] evicted;
		int held;
		int capacity;
		rsp_t words_due [$];
		int errors;

		function new();
			clear_history();
			capacity = HISTORY_SLOTS;
			errors = 0;
		endfunction

		function void clear_history();
			oldest = 1;
			upcoming = 1;
			evicted = 0;
			held = 0;
		endfunction

		function void evict_surplus();
			while (held > capacity) begin
				held--;
				oldest++;
				evicted++;
			end
		endfunction

		function void apply_capacity(logic [8:0] value);
			if (value == 0)
				capacity = 1;
			else if (value > HISTORY_SLOTS)
				capacity = HISTORY_SLOTS;
			else
				capacity = int'(value);
			evict_surplus();
		endfunction

		function entry_t slot_of(logic [OW-1:0] ord);
			return slots[int'(ord % HISTORY_SLOTS)];
		endfunction

		function void add_due(status_t st, logic [OW-1:0] ord, entry_t e, bit fin);
			rsp_t w;
			w.status = st;
			w.out_ordinal = ord;
			w.out_coll_id = e.coll_id;
			w.out_attempt = e.attempt;
			w.out_payload = e.payload;
			w.stored_count = 9'(held);
			w.evicted_total = evicted;
			w.oldest_ordinal = oldest;
			w.upcoming_ordinal = upcoming;
			w.last = fin;
			words_due = {words_due, w};
		endfunction

		function void note_request(req_t r);
			entry_t none;
			entry_t e;
			logic [OW-1:0] ord;
			int lim;
			int n;
			none = '0;
			case (r.cmd)
				CMD_RECORD: begin
					if (upcoming >= ORD_LAST) begin
						add_due(ST_EXHAUSTED, '0, none, 1'b1);
					end else begin
						e.coll_id = r.coll_id;
						e.attempt = r.attempt_no;
						e.payload = r.payload;
						slots[int'(upcoming % HISTORY_SLOTS)] = e;
						ord = upcoming;
						upcoming++;
						held++;
						evict_surplus();
						add_due(ST_OK, ord, none, 1'b1);
					end
				end
				CMD_GET: begin
					if (held == 0)
						add_due(ST_EMPTY, '0, none, 1'b1);
					else if (r.ordinal >= upcoming)
						add_due(ST_FUTURE, '0, none, 1'b1);
					else if (r.ordinal < oldest)
						add_due(ST_MISS, '0, none, 1'b1);
					else
						add_due(ST_OK, r.ordinal, slot_of(r.ordinal), 1'b1);
				end
				CMD_FIND: begin
					if (held == 0) begin
						add_due(ST_EMPTY, '0, none, 1'b1);
						return;
					end
					// Newest first; the first match wins.
					for (int i = 0; i < held; i++) begin
						ord = upcoming - 1 - i;
						e = slot_of(ord);
						if (e.coll_id == r.coll_id && (r.any_attempt || e.attempt == r.attempt_no)) begin
							add_due(ST_OK, ord, e, 1'b1);
							return;
						end
					end
					add_due(ST_MISS, '0, none, 1'b1);
				end
				CMD_LATEST: begin
					if (held == 0) begin
						add_due(ST_EMPTY, '0, none, 1'b1);
					end else begin
						lim = int'(r.limit);
						if (lim == 0)
							lim = 1;
						if (lim > int'(MAX_RES))
							lim = int'(MAX_RES);
						n = (lim < held) ? lim : held;
						for (int i = 0; i < n; i++) begin
							ord = upcoming - 1 - i;
							add_due(ST_OK, ord, slot_of(ord), i == n - 1);
						end
					end
				end
				CMD_CLEAR: begin
					clear_history();
					add_due(ST_OK, '0, none, 1'b1);
				end
				default: begin
					add_due(ST_OK, '0, none, 1'b1);
				end
			endcase
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		endtask

		task compare_field(string what, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report(what, got, want);
		endtask

		task check_word(rsp_t got);
			rsp_t want;
			if (words_due.size() == 0) begin
				report("response word with nothing due", 64'(got.out_ordinal), '0);
				return;
			end
			want = words_due[0];
			words_due.delete(0);
			compare_field("status", 64'(got.status), 64'(want.status));
			compare_field("out_ordinal", 64'(got.out_ordinal), 64'(want.out_ordinal));
			compare_field("out_coll_id", 64'(got.out_coll_id), 64'(want.out_coll_id));
			compare_field("out_attempt", 64'(got.out_attempt), 64'(want.out_attempt));
			compare_field("out_payload", got.out_payload, want.out_payload);
			compare_field("stored_count", 64'(got.stored_count), 64'(want.stored_count));
			compare_field("evicted_total", 64'(got.evicted_total), 64'(want.evicted_total));
			compare_field("oldest_ordinal", 64'(got.oldest_ordinal), 64'(want.oldest_ordinal));
			compare_field("upcoming_ordinal", 64'(got.upcoming_ordinal),
				64'(want.upcoming_ordinal));
			compare_field("last", 64'(got.last), 64'(want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [8:0] cfg_data;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	history_ledger ledger;
	int send_idle_pct;
	int recv_idle_pct;
	bit rsp_stall_req = 1'b0;
	bit stall_done = 1'b0;
	int stall_left = 0;

	ordinal_history_ring DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Response side: random back-pressure, plus one long hold-off on request.
	always @(negedge clk) begin
		if (rsp_stall_req && !stall_done) begin
			stall_done = 1'b1;
			stall_left = 400;
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready = 1'b0;
		end else begin
			rsp_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				ledger.apply_capacity(cfg_data);
			if (rsp_valid && rsp_ready)
				ledger.check_word(rsp);
			if (req_valid && req_ready)
				ledger.note_request(req);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req = r;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid = 1'b0;
		while (ledger.words_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(logic [8:0] value);
		drain();
		cfg_valid = 1'b1;
		cfg_data = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic req_t make_item(logic [2:0] cmd, logic [OW-1:0] ord, logic [31:0] id,
			logic [15:0] att, bit any, logic [63:0] pay, logic [6:0] lim);
		req_t r;
		r.cmd = cmd;
		r.ordinal = ord;
		r.coll_id = id;
		r.attempt_no = att;
		r.any_attempt = any;
		r.payload = pay;
		r.limit = lim;
		return r;
	endfunction

	// Fields the command does not use stay fully random; the used ones are
	// steered so that gets land near the window and finds often hit.
	function automatic req_t random_item();
		req_t r;
		int pick;
		int aim;
		r.cmd = CMD_RECORD;
		r.ordinal = {16'($urandom), $urandom};
		r.coll_id = $urandom;
		r.attempt_no = 16'($urandom);
		r.any_attempt = 1'($urandom);
		r.payload = {$urandom, $urandom};
		r.limit = 7'($urandom);
		pick = $urandom_range(99);
		aim = $urandom_range(99);
		if (pick < 46)
			r.cmd = CMD_RECORD;
		else if (pick < 66)
			r.cmd = CMD_GET;
		else if (pick < 80)
			r.cmd = CMD_FIND;
		else if (pick < 94)
			r.cmd = CMD_LATEST;
		else if (pick < 96)
			r.cmd = CMD_CLEAR;
		else
			r.cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
		case (r.cmd)
			CMD_RECORD, CMD_FIND: begin
				if (aim < 85)
					r.coll_id = $urandom_range(1) ? 32'($urandom_range(3)) : ~32'($urandom_range(3));
				if ($urandom_range(99) < 80)
					r.attempt_no = 16'($urandom_range(2));
			end
			CMD_GET: begin
				if (ledger.held > 0 && aim < 60)
					r.ordinal = ledger.upcoming - 1 - $urandom_range(ledger.held - 1);
				else if (aim < 75)
					r.ordinal = ledger.oldest - $urandom_range(3, 1);
				else if (aim < 88)
					r.ordinal = ledger.upcoming + $urandom_range(2);
			end
			CMD_LATEST: begin
				if (aim < 70)
					r.limit = 7'($urandom_range(8, 1));
				else if (aim < 90)
					r.limit = 7'($urandom_range(MAX_RES, 9));
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic run_random(int count);
		for (int k = 0; k < count; k++)
			send_item(random_item());
		drain();
	endtask

	task automatic run_directed();
		// Queries on an empty store.
		send_item(make_item(CMD_LATEST, '0, '0, '0, 1'b0, '0, 7'd1));
		send_item(make_item(CMD_GET, 48'd1, '0, '0, 1'b0, '0, '0));
		send_item(make_item(CMD_FIND, '0, '0, '0, 1'b0, '0, '0));
		// Records with extreme field values.
		send_item(make_item(CMD_RECORD, ORD_LAST, '0, '0, 1'b1, '0, '1));
		send_item(make_item(CMD_RECORD, '0, '1, '1, 1'b0, '1, '0));
		send_item(make_item(CMD_RECORD, '0, 32'h1234_5678, 16'd1, 1'b0,
			64'hA5A5_0F0F_C3C3_9696, 7'd3));
		send_item(make_item(CMD_GET, 48'd1, '0, '0, 1'b0, '0, '0));
		send_item(make_item(CMD_GET, '0, '0, '0, 1'b0, '0, '0));
		send_item(make_item(CMD_GET, ORD_LAST, '0, '0, 1'b0, '0, '0));
		send_item(make_item(CMD_GET, 48'd4, '0, '0, 1'b0, '0, '0));
		send_item(make_item(CMD_FIND, '0, '1, '1, 1'b0, '0, '0));
		send_item(make_item(CMD_FIND, '0, '1, '0, 1'b0, '0, '0));
		send_item(make_item(CMD_FIND, '0, '1, '0, 1'b1, '0, '0));
		// A limit of zero and one of 127, above the maximum.
		send_item(make_item(CMD_LATEST, '0, '0, '0, 1'b0, '0, 7'd0));
		send_item(make_item(CMD_LATEST, '0, '0, '0, 1'b0, '0, 7'd127));
		for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
			send_item(make_item(3'(c), '1, '1, '1, 1'b1, '1, '1));
		// A zero capacity keeps one record; the rest are evicted at once.
		write_capacity(9'd0);
		send_item(make_item(CMD_GET, 48'd1, '0, '0, 1'b0, '0, '0));
		send_item(make_item(CMD_GET, 48'd3, '0, '0, 1'b0, '0, '0));
		send_item(make_item(CMD_RECORD, '0, 32'h0000_0002, 16'd2, 1'b0, 64'd7, '0));
		send_item(make_item(CMD_LATEST, '0, '0, '0, 1'b0, '0, MAX_RES));
		send_item(make_item(CMD_CLEAR, '0, '0, '0, 1'b0, '0, '0));
		send_item(make_item(CMD_LATEST, '0, '0, '0, 1'b0, '0, 7'd5));
		send_item(make_item(CMD_RECORD, '0, 32'h0000_0003, 16'd0, 1'b0, 64'd9, '0));
		drain();
	endtask

	initial begin
		ledger = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		send_idle_pct = 35;
		recv_idle_pct = 71;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		write_capacity(9'd3);
		run_random(65);
		write_capacity(9'd256);
		run_random(65);

		send_idle_pct = 71;
		recv_idle_pct = 35;
		write_capacity(9'd1);
		run_random(65);
		write_capacity(9'd40);
		run_random(65);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// An oversized write clamps to the full depth.
		write_capacity(CAP_ALL_ONES);
		rsp_stall_req = 1'b1;
		run_random(70);
		write_capacity(9'd7);
		run_random(70);

		drain();
		repeat (40) @(negedge clk);
		if (ledger.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
